>>> src/hbgs_pkg.sv
// ----------------------------------------------------------------------------
// hbgs_pkg
// Shared types, constants and helpers of the history bar-graph scaler.
// ----------------------------------------------------------------------------
package hbgs_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int LED_COUNT     = 16;
  localparam int PERCENT_SCALE = 1000;

  localparam int READING_W = 16;
  localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
  localparam int ROW_W     = 3;
  localparam int PATTERN_W = 16;
  localparam int CHAN_W    = 2;

  // quotient never exceeds the percent scale, so it fits in QUOT_W bits
  localparam int QUOT_W   = $clog2(PERCENT_SCALE + 1);
  localparam int NUM_W    = READING_W + QUOT_W;
  localparam int SCALED_W = $clog2(PERCENT_SCALE * LED_COUNT + 1);
  localparam int STEP_W   = $clog2(QUOT_W + 1);

  localparam int REG_IDX_W = 3;
  localparam int CFG_AW    = REG_IDX_W + 2;
  localparam int CFG_DW    = 32;

  localparam logic [CHAN_W-1:0] CHAN_LIGHT = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_TEMP  = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_PRESS = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_CHANNEL     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_LOWER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_UPPER = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_LOWER  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_UPPER  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRESS_LOWER = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PRESS_UPPER = 3'd6;

  typedef struct packed {
    logic [READING_W-1:0] light;
    logic [READING_W-1:0] temp;
    logic [READING_W-1:0] press;
  } reading_set_t;

  // selected channel with its thresholds
  typedef struct packed {
    logic [CHAN_W-1:0]    chan;
    logic [READING_W-1:0] lower;
    logic [READING_W-1:0] upper;
  } sel_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_W-1:0]     num;
    logic [READING_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [HIST_AW-1:0] next_pos(input logic [HIST_AW-1:0] pos);
    logic [HIST_AW-1:0] res;
    if (pos == HIST_AW'(HISTORY_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = pos + HIST_AW'(1);
    end
    return res;
  endfunction

  // bit j is lit when led_count * percent reaches scale * (j + 1)
  function automatic logic [PATTERN_W-1:0] bar_pattern(input logic [QUOT_W-1:0] pct);
    logic [SCALED_W-1:0]  scaled;
    logic [PATTERN_W-1:0] pat;
    scaled = SCALED_W'(pct) * SCALED_W'(LED_COUNT);
    for (int j = 0; j < PATTERN_W; j++) begin
      pat[j] = (j < LED_COUNT) && (int'(scaled) >= PERCENT_SCALE * (j + 1));
    end
    return pat;
  endfunction

endpackage

>>> src/hbgs_regs.sv
// ----------------------------------------------------------------------------
// hbgs_regs
// APB register file: channel select and the per-channel thresholds.
// ----------------------------------------------------------------------------
module hbgs_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hbgs_pkg::CFG_AW-1:0]  paddr,
  input  logic [hbgs_pkg::CFG_DW-1:0]  pwdata,
  output logic [hbgs_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output hbgs_pkg::sel_t               sel_o
);
  import hbgs_pkg::*;

  logic [CHAN_W-1:0]    chan_q;
  logic [READING_W-1:0] light_lo_q, light_hi_q;
  logic [READING_W-1:0] temp_lo_q, temp_hi_q;
  logic [READING_W-1:0] press_lo_q, press_hi_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= CHAN_TEMP;
      light_lo_q <= '0;
      light_hi_q <= '1;
      temp_lo_q  <= '0;
      temp_hi_q  <= '1;
      press_lo_q <= '0;
      press_hi_q <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_CHANNEL:     chan_q     <= pwdata[CHAN_W-1:0];
        REG_LIGHT_LOWER: light_lo_q <= pwdata[READING_W-1:0];
        REG_LIGHT_UPPER: light_hi_q <= pwdata[READING_W-1:0];
        REG_TEMP_LOWER:  temp_lo_q  <= pwdata[READING_W-1:0];
        REG_TEMP_UPPER:  temp_hi_q  <= pwdata[READING_W-1:0];
        REG_PRESS_LOWER: press_lo_q <= pwdata[READING_W-1:0];
        REG_PRESS_UPPER: press_hi_q <= pwdata[READING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL:     prdata = CFG_DW'(chan_q);
      REG_LIGHT_LOWER: prdata = CFG_DW'(light_lo_q);
      REG_LIGHT_UPPER: prdata = CFG_DW'(light_hi_q);
      REG_TEMP_LOWER:  prdata = CFG_DW'(temp_lo_q);
      REG_TEMP_UPPER:  prdata = CFG_DW'(temp_hi_q);
      REG_PRESS_LOWER: prdata = CFG_DW'(press_lo_q);
      REG_PRESS_UPPER: prdata = CFG_DW'(press_hi_q);
      default:         prdata = '0;
    endcase
  end

  // unused channel code falls back to temperature
  always_comb begin
    case (chan_q)
      CHAN_LIGHT: begin
        sel_o.chan  = CHAN_LIGHT;
        sel_o.lower = light_lo_q;
        sel_o.upper = light_hi_q;
      end
      CHAN_PRESS: begin
        sel_o.chan  = CHAN_PRESS;
        sel_o.lower = press_lo_q;
        sel_o.upper = press_hi_q;
      end
      default: begin
        sel_o.chan  = CHAN_TEMP;
        sel_o.lower = temp_lo_q;
        sel_o.upper = temp_hi_q;
      end
    endcase
  end

endmodule

>>> src/hbgs_hist.sv
// ----------------------------------------------------------------------------
// hbgs_hist
// Ring history of samples with a write pointer and a registered read port.
// ----------------------------------------------------------------------------
module hbgs_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  hbgs_pkg::reading_set_t        wr_data_i,
  output logic [hbgs_pkg::HIST_AW-1:0]  wr_ptr_o,
  input  logic [hbgs_pkg::HIST_AW-1:0]  rd_addr_i,
  output hbgs_pkg::reading_set_t        rd_data_o
);
  import hbgs_pkg::*;

  reading_set_t       mem_q [HISTORY_DEPTH];
  reading_set_t       rd_data_q;
  logic [HIST_AW-1:0] ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      mem_q[ptr_q] <= wr_data_i;
      ptr_q        <= next_pos(ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign wr_ptr_o  = ptr_q;
  assign rd_data_o = rd_data_q;

endmodule

>>> src/hbgs_div.sv
// ----------------------------------------------------------------------------
// hbgs_div
// Restoring divider, one quotient bit per cycle, for the percent value.
// ----------------------------------------------------------------------------
module hbgs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hbgs_pkg::div_req_t           req_i,
  output hbgs_pkg::div_stat_t          stat_o,
  output logic [hbgs_pkg::QUOT_W-1:0]  quot_o
);
  import hbgs_pkg::*;

  logic [READING_W-1:0] rem_q;
  logic [READING_W-1:0] den_q;
  logic [QUOT_W-1:0]    low_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [STEP_W-1:0]    cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [READING_W:0]   trial;
  logic [READING_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper numerator bits start below the divisor, so the quotient fits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num[NUM_W-1:QUOT_W];
      low_q  <= req_i.num[QUOT_W-1:0];
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[READING_W-1:0] : trial[READING_W-1:0];
      low_q  <= {low_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

>>> src/history_bar_graph_scaler.sv
// Each row passes through read, clamp, divider load, 10 divider steps, hand-off
// and emit, starting with the first row after a sample is taken.
// A new sample is not taken until all rows of the last one are out; the 10-step
// shared divider sets the row time. in_stall_o is high until the last row is out.
// Reset clears the history to zero, the pointer to zero and the registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// history_bar_graph_scaler
// Keeps a ring of sensor samples and emits one bar-graph row per entry.
// ----------------------------------------------------------------------------
module history_bar_graph_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hbgs_pkg::CFG_AW-1:0]     paddr,
  input  logic [hbgs_pkg::CFG_DW-1:0]     pwdata,
  output logic [hbgs_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hbgs_pkg::READING_W-1:0]  light_reading_i,
  input  logic [hbgs_pkg::READING_W-1:0]  temp_reading_i,
  input  logic [hbgs_pkg::READING_W-1:0]  press_reading_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hbgs_pkg::ROW_W-1:0]      row_index_o,
  output logic [hbgs_pkg::PATTERN_W-1:0]  row_pattern_o,
  output logic                            threshold_error_o,
  output logic                            last_row_o
);
  import hbgs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  sel_t                 sel;
  reading_set_t         wr_sample;
  reading_set_t         rd_sample;
  logic [HIST_AW-1:0]   wr_ptr;
  div_req_t             div_req;
  div_stat_t            div_stat;
  logic [QUOT_W-1:0]    quot;

  logic [2:0]           state_q;
  logic [HIST_AW-1:0]   rd_pos_q;
  logic [HIST_AW-1:0]   row_q;
  logic [READING_W-1:0] diff_q;
  logic [READING_W-1:0] span_q;
  logic                 err_q;
  logic                 accept;
  logic                 is_last;
  logic                 emit;
  logic [READING_W-1:0] reading;
  logic [READING_W-1:0] clamped;

  logic                 out_valid_q;
  logic [ROW_W-1:0]     row_index_q;
  logic [PATTERN_W-1:0] row_pattern_q;
  logic                 err_out_q;
  logic                 last_q;

  hbgs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sel_o   (sel)
  );

  assign wr_sample.light = light_reading_i;
  assign wr_sample.temp  = temp_reading_i;
  assign wr_sample.press = press_reading_i;

  hbgs_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (wr_sample),
    .wr_ptr_o  (wr_ptr),
    .rd_addr_i (rd_pos_q),
    .rd_data_o (rd_sample)
  );

  assign div_req.start = (state_q == S_START);
  assign div_req.num   = NUM_W'(diff_q) * NUM_W'(PERCENT_SCALE);
  assign div_req.den   = span_q;

  hbgs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_last    = (row_q == HIST_AW'(HISTORY_DEPTH - 1));
  assign emit       = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (sel.chan)
      CHAN_LIGHT: reading = rd_sample.light;
      CHAN_PRESS: reading = rd_sample.press;
      default:    reading = rd_sample.temp;
    endcase
  end

  always_comb begin
    clamped = reading;
    if (clamped > sel.upper) begin
      clamped = sel.upper;
    end
    if (clamped < sel.lower) begin
      clamped = sel.lower;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_pos_q <= '0;
      row_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            rd_pos_q <= next_pos(wr_ptr);
            row_q    <= '0;
            state_q  <= S_READ;
          end
        end
        S_READ:  state_q <= S_CALC;
        S_CALC:  state_q <= S_START;
        S_START: state_q <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              row_q    <= row_q + HIST_AW'(1);
              rd_pos_q <= next_pos(rd_pos_q);
              state_q  <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      diff_q <= clamped - sel.lower;
      span_q <= sel.upper - sel.lower;
      err_q  <= (sel.upper <= sel.lower);
    end
  end

  // output word register parts the row sequencer from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_index_q   <= ROW_W'(row_q);
      row_pattern_q <= err_q ? '0 : bar_pattern(quot);
      err_out_q     <= err_q;
      last_q        <= is_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign row_index_o       = row_index_q;
  assign row_pattern_o     = row_pattern_q;
  assign threshold_error_o = err_out_q;
  assign last_row_o        = last_q;

  // divider is never left running when a new sample can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |-> (row_index_o == ROW_W'(HISTORY_DEPTH - 1)))
    else $error("last row flag on wrong row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && threshold_error_o) |-> (row_pattern_o == '0))
    else $error("pattern lit with threshold error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider result with no row waiting");

endmodule
